FILE: rtl/monthly_temperature_statistics_unit_defines.svh
// ----------------------------------------------------------------------------
// Monthly temperature statistics unit: assertion macros
// Shorthand for the clocked implication checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef MONTHLY_TEMPERATURE_STATISTICS_UNIT_DEFINES_SVH
`define MONTHLY_TEMPERATURE_STATISTICS_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MTS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Constants, codes and types of the monthly temperature statistics unit.
// ----------------------------------------------------------------------------
package mts_pkg;

  // Default width of a month's sample counter
  localparam int COUNT_BITS_DEF = 24;
  // Year aggregate counter width (fixed by the result field)
  localparam int YEAR_COUNT_BITS = 28;
  localparam int TEMP_BITS       = 8;
  localparam int YEAR_BITS       = 12;
  localparam int ERR_BITS        = 7;
  localparam int NUM_MONTHS      = 12;
  localparam int MONTH_IDX_BITS  = 4;

  // Quotient bits of the average; |average| never exceeds 128
  localparam int QUO_BITS  = 8;
  localparam int STEP_BITS = $clog2(QUO_BITS);

  // Field limits
  localparam logic [3:0] MONTH_MAX  = 4'd12;
  localparam logic [5:0] DAY_MAX    = 6'd31;
  localparam logic [4:0] HOUR_MAX   = 5'd23;
  localparam logic [5:0] MINUTE_MAX = 6'd59;

  // Configuration reset values
  localparam logic [YEAR_BITS-1:0]        YEAR_LOW_RST  = 12'd2000;
  localparam logic [YEAR_BITS-1:0]        YEAR_HIGH_RST = 12'd2100;
  localparam logic signed [TEMP_BITS-1:0] TEMP_LOW_RST  = -8'sd99;
  localparam logic signed [TEMP_BITS-1:0] TEMP_HIGH_RST = 8'sd99;

  // Operation codes
  localparam logic OP_RECORD = 1'b0;
  localparam logic OP_REPORT = 1'b1;

  // Error mask bit positions
  localparam int ERR_YEAR   = 0;
  localparam int ERR_MONTH  = 1;
  localparam int ERR_DAY    = 2;
  localparam int ERR_HOUR   = 3;
  localparam int ERR_MINUTE = 4;
  localparam int ERR_TEMP   = 5;
  localparam int ERR_FULL   = 6;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_YEAR_LOW  = 2'd0,
    CFG_YEAR_HIGH = 2'd1,
    CFG_TEMP_LOW  = 2'd2,
    CFG_TEMP_HIGH = 2'd3
  } cfg_reg_t;

  // Sequencer states
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_DIV  = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

endpackage

FILE: rtl/monthly_temperature_statistics_unit.sv
// ----------------------------------------------------------------------------
// monthly_temperature_statistics_unit
// Binned min / max / mean accumulator over twelve months and a year total.
// ----------------------------------------------------------------------------
// Usage:
//   Input items arrive on in_* (tuser = op: 0 record a sample, 1 report).
//   A record is range-checked and, when clean, added to its month bin and to
//   the year aggregate; its result carries only the error mask. A report for
//   month 1-12, or 0 for the whole year, returns has_data (out_tuser), the
//   average truncated toward zero, maximum, minimum and sample count.
//   Every item yields exactly one result item on out_*.
//   Throughput: one item at a time; in_tready stays low from acceptance
//   until the result moves into the output register. A record passes EXEC
//   and DONE; a report on a non-empty bin also passes DIV in between, the
//   eight-step restoring divider that forms the average.
//   A finished result waits in the output register while the next item is
//   accepted; if the receiver stalls, the block holds its next result until
//   the output register empties.
//   Reset (rst_n low, synchronous) clears sums, counts, the sequencer and the
//   output valid, and loads the default limits. Limit writes on cfg_* take
//   effect at once; the user makes them while the block is idle (unchecked).
// ----------------------------------------------------------------------------
`include "monthly_temperature_statistics_unit_defines.svh"

module monthly_temperature_statistics_unit #(
  parameter int COUNT_BITS = mts_pkg::COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  // year[11:0], month[15:12], day[21:16], hour[26:22], minute[32:27],
  // temperature[40:33], zero fill[47:41]
  input  logic [47:0] in_tdata,
  // op[0]
  input  logic        in_tuser,

  output logic        out_tvalid,
  input  logic        out_tready,
  // error_mask[6:0], average[14:7], maximum[22:15], minimum[30:23],
  // sample_count[58:31], zero fill[63:59]
  output logic [63:0] out_tdata,
  // has_data[0]
  output logic        out_tuser,

  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_wdata
);

  localparam int YCB = mts_pkg::YEAR_COUNT_BITS;
  localparam int TB  = mts_pkg::TEMP_BITS;
  localparam int QB  = mts_pkg::QUO_BITS;
  localparam int NM  = mts_pkg::NUM_MONTHS;
  localparam int MIB = mts_pkg::MONTH_IDX_BITS;
  // Month sum width: count times the largest magnitude of a temperature
  localparam int MSB_W = COUNT_BITS + TB;
  localparam int YSB_W = YCB + TB;
  // Shared divider width covers both the month and the year bins
  localparam int CW    = (COUNT_BITS > YCB) ? COUNT_BITS : YCB;
  localparam int SW    = CW + TB;
  localparam logic [mts_pkg::STEP_BITS-1:0] LAST_STEP = mts_pkg::STEP_BITS'(QB - 1);

  // Sequencer
  mts_pkg::state_t state_r, state_nxt;

  // Latched item
  logic                  op_r;
  logic [11:0]           year_r;
  logic [3:0]            month_r;
  logic [5:0]            day_r;
  logic [4:0]            hour_r;
  logic [5:0]            minute_r;
  logic signed [TB-1:0]  temp_r;

  // Limits
  logic [11:0]          year_low_r, year_high_r;
  logic signed [TB-1:0] temp_low_r, temp_high_r;

  // Bins
  logic signed [MSB_W-1:0]    month_sum_r   [NM];
  logic [COUNT_BITS-1:0]      month_count_r [NM];
  logic signed [TB-1:0]       month_max_r   [NM];
  logic signed [TB-1:0]       month_min_r   [NM];
  logic signed [YSB_W-1:0]    year_sum_r;
  logic [YCB-1:0]             year_count_r;
  logic signed [TB-1:0]       year_max_r, year_min_r;

  // Divider and staged result
  logic [SW-1:0]                     rem_r, dvs_r;
  logic [QB-1:0]                     quo_r;
  logic [mts_pkg::STEP_BITS-1:0]     step_r;
  logic                              neg_r;
  logic [mts_pkg::ERR_BITS-1:0]      res_err_r;
  logic                              res_has_r;
  logic signed [TB-1:0]              sel_max_r, sel_min_r;
  logic [CW-1:0]                     sel_cnt_r;

  // Output register
  logic                              out_valid_r;
  logic [mts_pkg::ERR_BITS-1:0]      out_err_r;
  logic                              out_has_r;
  logic signed [TB-1:0]              out_avg_r, out_max_r, out_min_r;
  logic [YCB-1:0]                    out_cnt_r;

  // Decode of the latched item
  logic                         month_bad;
  logic [MIB-1:0]               idx;
  logic [mts_pkg::ERR_BITS-1:0] range_err;
  logic                         bin_full;
  logic                         rec_ok;
  logic                         rpt_bad;
  logic [mts_pkg::ERR_BITS-1:0] rec_err;
  logic [mts_pkg::ERR_BITS-1:0] rpt_err;
  logic [CW-1:0]                sel_cnt;
  logic signed [SW-1:0]         sel_sum;
  logic [SW-1:0]                sel_mag;
  logic [SW:0]                  diff;
  logic                         out_free;
  logic signed [TB-1:0]         avg_val;

  assign in_tready = (state_r == mts_pkg::S_IDLE);
  assign out_free  = !out_valid_r || out_tready;

  always_comb begin
    month_bad = (month_r == 4'd0) || (month_r > mts_pkg::MONTH_MAX);
    idx       = month_bad ? '0 : (month_r - 4'd1);

    range_err = '0;
    range_err[mts_pkg::ERR_YEAR]   = (year_r < year_low_r) || (year_r > year_high_r);
    range_err[mts_pkg::ERR_MONTH]  = month_bad;
    range_err[mts_pkg::ERR_DAY]    = (day_r == 6'd0) || (day_r > mts_pkg::DAY_MAX);
    range_err[mts_pkg::ERR_HOUR]   = hour_r > mts_pkg::HOUR_MAX;
    range_err[mts_pkg::ERR_MINUTE] = minute_r > mts_pkg::MINUTE_MAX;
    range_err[mts_pkg::ERR_TEMP]   = (temp_r < temp_low_r) || (temp_r > temp_high_r);

    // Drop the sample when either counter would wrap
    bin_full = (month_count_r[idx] == '1) || (year_count_r == '1);
    rec_ok   = (range_err == '0) && !bin_full;
    rpt_bad  = month_r > mts_pkg::MONTH_MAX;

    rec_err = range_err;
    rec_err[mts_pkg::ERR_FULL] = (range_err == '0) && bin_full;
    rpt_err = '0;
    rpt_err[mts_pkg::ERR_MONTH] = rpt_bad;

    if (month_r == 4'd0) begin
      sel_cnt = CW'(year_count_r);
      sel_sum = SW'(year_sum_r);
    end else begin
      sel_cnt = CW'(month_count_r[idx]);
      sel_sum = SW'(month_sum_r[idx]);
    end
    sel_mag = sel_sum[SW-1] ? SW'(-sel_sum) : SW'(sel_sum);

    // Shared subtractor: one quotient bit per cycle
    diff    = {1'b0, rem_r} - {1'b0, dvs_r};
    avg_val = neg_r ? TB'(~quo_r + QB'(1)) : TB'(quo_r);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mts_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = mts_pkg::S_EXEC;
      end
      mts_pkg::S_EXEC: begin
        if (op_r == mts_pkg::OP_REPORT && !rpt_bad && sel_cnt != '0) begin
          state_nxt = mts_pkg::S_DIV;
        end else begin
          state_nxt = mts_pkg::S_DONE;
        end
      end
      mts_pkg::S_DIV: begin
        if (step_r == LAST_STEP) state_nxt = mts_pkg::S_DONE;
      end
      mts_pkg::S_DONE: begin
        if (out_free) state_nxt = mts_pkg::S_IDLE;
      end
      default: state_nxt = mts_pkg::S_IDLE;
    endcase
  end

  // Control and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mts_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      year_low_r  <= mts_pkg::YEAR_LOW_RST;
      year_high_r <= mts_pkg::YEAR_HIGH_RST;
      temp_low_r  <= mts_pkg::TEMP_LOW_RST;
      temp_high_r <= mts_pkg::TEMP_HIGH_RST;
    end else begin
      state_r <= state_nxt;
      if (state_r == mts_pkg::S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (mts_pkg::cfg_reg_t'(cfg_index))
          mts_pkg::CFG_YEAR_LOW:  year_low_r  <= cfg_wdata;
          mts_pkg::CFG_YEAR_HIGH: year_high_r <= cfg_wdata;
          mts_pkg::CFG_TEMP_LOW:  temp_low_r  <= cfg_wdata[TB-1:0];
          mts_pkg::CFG_TEMP_HIGH: temp_high_r <= cfg_wdata[TB-1:0];
          default: ;
        endcase
      end
    end
  end

  // Sums and counts: cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NM; i++) begin
        month_sum_r[i]   <= '0;
        month_count_r[i] <= '0;
      end
      year_sum_r   <= '0;
      year_count_r <= '0;
    end else if (state_r == mts_pkg::S_EXEC && op_r == mts_pkg::OP_RECORD && rec_ok) begin
      month_sum_r[idx]   <= month_sum_r[idx] + MSB_W'(temp_r);
      month_count_r[idx] <= month_count_r[idx] + COUNT_BITS'(1);
      year_sum_r         <= year_sum_r + YSB_W'(temp_r);
      year_count_r       <= year_count_r + YCB'(1);
    end
  end

  // Extremes: loaded from a bin's first sample, no reset
  always_ff @(posedge clk) begin
    if (state_r == mts_pkg::S_EXEC && op_r == mts_pkg::OP_RECORD && rec_ok) begin
      if (month_count_r[idx] == '0 || temp_r > month_max_r[idx]) month_max_r[idx] <= temp_r;
      if (month_count_r[idx] == '0 || temp_r < month_min_r[idx]) month_min_r[idx] <= temp_r;
      if (year_count_r == '0 || temp_r > year_max_r) year_max_r <= temp_r;
      if (year_count_r == '0 || temp_r < year_min_r) year_min_r <= temp_r;
    end
  end

  // Item capture, divider and result staging
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      op_r     <= in_tuser;
      year_r   <= in_tdata[11:0];
      month_r  <= in_tdata[15:12];
      day_r    <= in_tdata[21:16];
      hour_r   <= in_tdata[26:22];
      minute_r <= in_tdata[32:27];
      temp_r   <= in_tdata[40:33];
    end

    case (state_r)
      mts_pkg::S_EXEC: begin
        step_r <= '0;
        quo_r  <= '0;
        if (op_r == mts_pkg::OP_RECORD) begin
          res_err_r <= rec_err;
          res_has_r <= 1'b0;
        end else begin
          res_err_r <= rpt_err;
          res_has_r <= !rpt_bad && (sel_cnt != '0);
        end
        // Load the divider: |sum| against count scaled to the top quotient bit
        rem_r     <= sel_mag;
        dvs_r     <= SW'({sel_cnt, {(QB-1){1'b0}}});
        neg_r     <= sel_sum[SW-1];
        sel_cnt_r <= sel_cnt;
        if (month_r == 4'd0) begin
          sel_max_r <= year_max_r;
          sel_min_r <= year_min_r;
        end else begin
          sel_max_r <= month_max_r[idx];
          sel_min_r <= month_min_r[idx];
        end
      end
      mts_pkg::S_DIV: begin
        if (!diff[SW]) begin
          rem_r <= diff[SW-1:0];
          quo_r <= {quo_r[QB-2:0], 1'b1};
        end else begin
          quo_r <= {quo_r[QB-2:0], 1'b0};
        end
        dvs_r  <= dvs_r >> 1;
        step_r <= step_r + mts_pkg::STEP_BITS'(1);
      end
      mts_pkg::S_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_err_r <= res_err_r;
          out_has_r <= res_has_r;
          out_avg_r <= res_has_r ? avg_val : '0;
          out_max_r <= res_has_r ? sel_max_r : '0;
          out_min_r <= res_has_r ? sel_min_r : '0;
          out_cnt_r <= res_has_r ? sel_cnt_r[YCB-1:0] : '0;
        end
      end
      default: ;
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_has_r;
  assign out_tdata  = {5'b0, out_cnt_r, out_min_r, out_max_r, out_avg_r, out_err_r};

  // Checks
  `MTS_ASSERT_NXT(a_accept_exec, clk, rst_n, in_tvalid && in_tready,
    state_r == mts_pkg::S_EXEC, "accepted item did not enter execution")
  `MTS_ASSERT_NXT(a_div_ends, clk, rst_n, state_r == mts_pkg::S_DIV && step_r == LAST_STEP,
    state_r == mts_pkg::S_DONE, "divider overran its step count")
  `MTS_ASSERT_NXT(a_no_overwrite, clk, rst_n,
    state_r == mts_pkg::S_DONE && out_valid_r && !out_tready,
    state_r == mts_pkg::S_DONE, "result dropped while output stalled")
  `MTS_ASSERT_IMP(a_err_no_data, clk, rst_n, out_valid_r && out_err_r != '0,
    !out_has_r, "error result flagged as holding data")
  `MTS_ASSERT_IMP(a_avg_in_range, clk, rst_n, out_valid_r && out_has_r,
    out_min_r <= out_avg_r && out_avg_r <= out_max_r, "average outside min and max")

endmodule
